### hdl/gtq_pkg.sv
package gtq_pkg;

    localparam int OCC_BITS    = 7;
    localparam int STATUS_BITS = 2;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ_ALLOC,
        S_ENQ_READ_LINK,
        S_ENQ_LINK_PREV,
        S_DEQ_READ,
        S_DEQ_TEAM,
        S_HOLD
    } t_state;

endpackage

### hdl/gtq_ram.sv
module gtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/grouped_team_queue_core.sv
// Bounded team queue. An enqueue beat (tuser = 0) stores its data word behind the last
// waiting member of the same team, or at the tail when no member of that team waits; a
// dequeue beat (tuser = 1) returns the head entry. Every input beat gives exactly one
// output beat carrying data, team, status and occupancy. The slot, link, team and free
// tables sit in simple dual-port synchronous memories (one read port, one write port) with
// registered reads: a refused enqueue or empty dequeue ends in idle, an enqueue that
// appends or starts an empty queue ends in allocation, a dequeue runs a head read then
// a team update, and an enqueue inserted behind a team member mid-queue runs allocation,
// link read and link write, since the link memory is read and then written twice.
// Results pass through an output register, so the next beat is taken while a result
// waits. After reset the team table is swept, one entry a cycle, before any beat is taken.
module grouped_team_queue_core #(
    parameter int CAPACITY  = 64,
    parameter int DATA_BITS = 16,
    parameter int TEAM_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // in_data, in_team
    input  logic [((DATA_BITS+TEAM_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // op
    input  logic [0:0]                                   s_axis_tuser,

    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // out_data, out_team, occupancy
    output logic [((DATA_BITS+TEAM_BITS+7+7)/8)*8-1:0]   m_axis_tdata,
    // status
    output logic [1:0]                                   m_axis_tuser
);

    localparam int AW         = $clog2(CAPACITY);
    localparam int CW         = $clog2(CAPACITY + 1);
    localparam int TEAM_DEPTH = 1 << TEAM_BITS;
    localparam int OUT_W      = ((DATA_BITS + TEAM_BITS + gtq_pkg::OCC_BITS + 7) / 8) * 8;

    gtq_pkg::t_state r_state, n_state;

    logic [DATA_BITS-1:0] r_data, n_data;
    logic [TEAM_BITS-1:0] r_team, n_team;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_fresh, n_fresh;
    logic [CW-1:0]        r_top, n_top;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_tail, n_tail;
    logic [AW-1:0]        r_slot, n_slot;
    logic [AW-1:0]        r_prev, n_prev;
    logic [TEAM_BITS:0]   r_clr, n_clr;

    logic [DATA_BITS-1:0]     r_res_data, n_res_data;
    logic [TEAM_BITS-1:0]     r_res_team, n_res_team;
    gtq_pkg::t_status         r_res_status, n_res_status;

    logic                          r_out_valid, n_out_valid;
    logic [DATA_BITS-1:0]          r_out_data, n_out_data;
    logic [TEAM_BITS-1:0]          r_out_team, n_out_team;
    gtq_pkg::t_status              r_out_status, n_out_status;
    logic [gtq_pkg::OCC_BITS-1:0]  r_out_occ, n_out_occ;

    // memory ports
    logic                            slot_we;
    logic [AW-1:0]                   slot_waddr, slot_raddr;
    logic [DATA_BITS+TEAM_BITS-1:0]  slot_wdata, slot_q;
    logic                            link_we;
    logic [AW-1:0]                   link_waddr, link_raddr, link_wdata, link_q;
    logic                            team_we;
    logic [TEAM_BITS-1:0]            team_waddr, team_raddr;
    logic [AW:0]                     team_wdata, team_q;
    logic                            stk_we;
    logic [AW-1:0]                   stk_waddr, stk_raddr, stk_wdata, stk_q;

    logic                 fin;
    gtq_pkg::t_status     fin_status;
    logic [DATA_BITS-1:0] fin_data;
    logic [TEAM_BITS-1:0] fin_team;
    logic                 out_free;
    logic                 full;
    logic [AW-1:0]        new_slot;
    logic [CW-1:0]        top_dec;

    gtq_ram #(.WIDTH(DATA_BITS + TEAM_BITS), .DEPTH(CAPACITY)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_q)
    );

    gtq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_q)
    );

    gtq_ram #(.WIDTH(AW + 1), .DEPTH(TEAM_DEPTH)) u_team_ram (
        .i_clk   (i_clk),
        .i_we    (team_we),
        .i_waddr (team_waddr),
        .i_wdata (team_wdata),
        .i_raddr (team_raddr),
        .o_rdata (team_q)
    );

    gtq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign full     = (r_count == CW'(CAPACITY));
    assign top_dec  = r_top - CW'(1);
    // never-used slots first, then recycled ones from the free stack
    assign new_slot = (r_fresh != CW'(CAPACITY)) ? r_fresh[AW-1:0] : stk_q;

    assign s_axis_tready = (r_state == gtq_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_occ, r_out_team, r_out_data});
    assign m_axis_tuser  = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_data       = r_data;
        n_team       = r_team;
        n_count      = r_count;
        n_fresh      = r_fresh;
        n_top        = r_top;
        n_head       = r_head;
        n_tail       = r_tail;
        n_slot       = r_slot;
        n_prev       = r_prev;
        n_clr        = r_clr;
        n_res_data   = r_res_data;
        n_res_team   = r_res_team;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_team   = r_out_team;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;

        slot_we    = 1'b0;
        slot_waddr = new_slot;
        slot_wdata = {r_team, r_data};
        slot_raddr = r_head;
        link_we    = 1'b0;
        link_waddr = r_tail;
        link_wdata = new_slot;
        link_raddr = r_head;
        team_we    = 1'b0;
        team_waddr = r_team;
        team_wdata = {1'b1, new_slot};
        team_raddr = s_axis_tdata[DATA_BITS +: TEAM_BITS];
        stk_we     = 1'b0;
        stk_waddr  = r_top[AW-1:0];
        stk_wdata  = r_head;
        stk_raddr  = top_dec[AW-1:0];

        fin        = 1'b0;
        fin_status = gtq_pkg::ST_ENQ;
        fin_data   = '0;
        fin_team   = '0;

        case (r_state)
            gtq_pkg::S_CLEAR: begin
                team_we    = 1'b1;
                team_waddr = r_clr[TEAM_BITS-1:0];
                team_wdata = '0;
                n_clr      = r_clr + (TEAM_BITS+1)'(1);
                if (r_clr == (TEAM_BITS+1)'(TEAM_DEPTH - 1)) begin
                    n_state = gtq_pkg::S_IDLE;
                end
            end
            gtq_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_data = s_axis_tdata[DATA_BITS-1:0];
                    n_team = s_axis_tdata[DATA_BITS +: TEAM_BITS];
                    if (s_axis_tuser[0] == gtq_pkg::OP_ENQ) begin
                        if (full) begin
                            fin        = 1'b1;
                            fin_status = gtq_pkg::ST_FULL;
                        end else begin
                            n_state = gtq_pkg::S_ENQ_ALLOC;
                        end
                    end else begin
                        if (r_count == '0) begin
                            fin        = 1'b1;
                            fin_status = gtq_pkg::ST_EMPTY;
                        end else begin
                            n_state = gtq_pkg::S_DEQ_READ;
                        end
                    end
                end
            end
            gtq_pkg::S_ENQ_ALLOC: begin
                slot_we = 1'b1;
                team_we = 1'b1;
                n_count = r_count + CW'(1);
                if (r_fresh != CW'(CAPACITY)) begin
                    n_fresh = r_fresh + CW'(1);
                end else begin
                    n_top = top_dec;
                end
                if (r_count == '0) begin
                    n_head     = new_slot;
                    n_tail     = new_slot;
                    fin        = 1'b1;
                    fin_status = gtq_pkg::ST_ENQ;
                end else if (team_q[AW] && team_q[AW-1:0] != r_tail) begin
                    // insert behind the team's last member: fetch its link first
                    link_raddr = team_q[AW-1:0];
                    n_prev     = team_q[AW-1:0];
                    n_slot     = new_slot;
                    n_state    = gtq_pkg::S_ENQ_READ_LINK;
                end else begin
                    link_we    = 1'b1;
                    n_tail     = new_slot;
                    fin        = 1'b1;
                    fin_status = gtq_pkg::ST_ENQ;
                end
            end
            gtq_pkg::S_ENQ_READ_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_slot;
                link_wdata = link_q;
                n_state    = gtq_pkg::S_ENQ_LINK_PREV;
            end
            gtq_pkg::S_ENQ_LINK_PREV: begin
                link_we    = 1'b1;
                link_waddr = r_prev;
                link_wdata = r_slot;
                fin        = 1'b1;
                fin_status = gtq_pkg::ST_ENQ;
            end
            gtq_pkg::S_DEQ_READ: begin
                n_res_data = slot_q[DATA_BITS-1:0];
                n_res_team = slot_q[DATA_BITS +: TEAM_BITS];
                n_team     = slot_q[DATA_BITS +: TEAM_BITS];
                team_raddr = slot_q[DATA_BITS +: TEAM_BITS];
                n_slot     = r_head;
                // release the head slot onto the free stack
                stk_we     = 1'b1;
                n_top      = r_top + CW'(1);
                n_count    = r_count - CW'(1);
                if (r_count != CW'(1)) begin
                    n_head = link_q;
                end
                n_state    = gtq_pkg::S_DEQ_TEAM;
            end
            gtq_pkg::S_DEQ_TEAM: begin
                if (team_q[AW] && team_q[AW-1:0] == r_slot) begin
                    team_we    = 1'b1;
                    team_wdata = '0;
                end
                fin        = 1'b1;
                fin_status = gtq_pkg::ST_DEQ;
                fin_data   = r_res_data;
                fin_team   = r_res_team;
            end
            gtq_pkg::S_HOLD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_team   = r_res_team;
                    n_out_status = r_res_status;
                    n_out_occ    = gtq_pkg::OCC_BITS'(r_count);
                    n_state      = gtq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gtq_pkg::S_IDLE;
            end
        endcase

        // deliver now if the output register frees up, else park the result
        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_data   = fin_data;
                n_out_team   = fin_team;
                n_out_status = fin_status;
                n_out_occ    = gtq_pkg::OCC_BITS'(n_count);
                n_state      = gtq_pkg::S_IDLE;
            end else begin
                n_res_data   = fin_data;
                n_res_team   = fin_team;
                n_res_status = fin_status;
                n_state      = gtq_pkg::S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gtq_pkg::S_CLEAR;
            r_count     <= '0;
            r_fresh     <= '0;
            r_top       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_top       <= n_top;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data       <= n_data;
        r_team       <= n_team;
        r_slot       <= n_slot;
        r_prev       <= n_prev;
        r_res_data   <= n_res_data;
        r_res_team   <= n_res_team;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_team   <= n_out_team;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_slot_accounting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + {1'b0, r_top}) == {1'b0, r_fresh})
        else $error("slots lost or duplicated between queue and free stack");

    a_no_beat_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gtq_pkg::S_CLEAR) |-> !s_axis_tready)
        else $error("beat accepted during team table sweep");

    a_park_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gtq_pkg::S_HOLD && n_state == gtq_pkg::S_HOLD) |-> !out_free)
        else $error("result parked although the output register was free");

endmodule

### dv/grouped_team_queue_core_checker.sv
`timescale 1ns / 100ps

module grouped_team_queue_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,      // in_data, in_team
    input  logic [0:0]  i_s_tuser,      // op

    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,      // out_data, out_team, occupancy
    input  logic [1:0]  i_m_tuser,      // status

    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_full_count,
    output int          o_empty_count,
    output int          o_insert_count,
    output int          o_peak_occ
);

    localparam int CAPACITY = 64;

    typedef struct packed {
        logic [15:0]      data;
        logic [7:0]       team;
        gtq_pkg::t_status status;
        logic [6:0]       occ;
    } t_beat_result;

    // shadow copy of the linked slot store
    logic [15:0]  slot_data [CAPACITY];
    logic [7:0]   slot_team [CAPACITY];
    logic [5:0]   slot_next [CAPACITY];
    bit   [255:0] team_waiting;
    logic [5:0]   team_last_slot [256];
    bit   [63:0]  free_map;
    logic [5:0]   head_idx;
    logic [5:0]   tail_idx;
    int           queued;

    t_beat_result pending_results [$];
    int fails;
    int results;
    int full_refusals;
    int empty_dequeues;
    int mid_inserts;
    int peak_occ;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    function automatic t_beat_result advance_team_queue(input gtq_pkg::t_op op,
                                                        input logic [15:0] data,
                                                        input logic [7:0] team);
        t_beat_result res;
        logic [5:0]   slot;
        logic [5:0]   prev;
        res  = '0;
        slot = '0;
        if (op == gtq_pkg::OP_ENQ) begin
            if (queued >= CAPACITY) begin
                res.status = gtq_pkg::ST_FULL;
                full_refusals++;
            end else begin
                // take the lowest free slot
                for (int i = CAPACITY - 1; i >= 0; i--)
                    if (free_map[i]) slot = i[5:0];
                free_map[slot]  = 1'b0;
                slot_data[slot] = data;
                slot_team[slot] = team;
                if (queued == 0) begin
                    head_idx = slot;
                    tail_idx = slot;
                end else if (team_waiting[team] && team_last_slot[team] != tail_idx) begin
                    prev            = team_last_slot[team];
                    slot_next[slot] = slot_next[prev];
                    slot_next[prev] = slot;
                    mid_inserts++;
                end else begin
                    slot_next[tail_idx] = slot;
                    tail_idx            = slot;
                end
                team_waiting[team]   = 1'b1;
                team_last_slot[team] = slot;
                queued++;
                res.status = gtq_pkg::ST_ENQ;
            end
        end else begin
            if (queued == 0) begin
                res.status = gtq_pkg::ST_EMPTY;
                empty_dequeues++;
            end else begin
                slot     = head_idx;
                res.data = slot_data[slot];
                res.team = slot_team[slot];
                // last member leaving clears the team's entry
                if (team_waiting[res.team] && team_last_slot[res.team] == slot)
                    team_waiting[res.team] = 1'b0;
                free_map[slot] = 1'b1;
                queued--;
                if (queued != 0)
                    head_idx = slot_next[slot];
                res.status = gtq_pkg::ST_DEQ;
            end
        end
        res.occ = queued[6:0];
        if (queued > peak_occ)
            peak_occ = queued;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_beat_result got;
        t_beat_result want;
        if (!i_rst_n) begin
            free_map       = '1;
            team_waiting   = '0;
            head_idx       = '0;
            tail_idx       = '0;
            queued         = 0;
            pending_results.delete();
            results        = 0;
            full_refusals  = 0;
            empty_dequeues = 0;
            mid_inserts    = 0;
            peak_occ       = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(advance_team_queue(gtq_pkg::t_op'(i_s_tuser),
                                                             i_s_tdata[15:0], i_s_tdata[23:16]));
            if (i_m_tvalid && i_m_tready) begin
                got.data   = i_m_tdata[15:0];
                got.team   = i_m_tdata[23:16];
                got.occ    = i_m_tdata[30:24];
                got.status = gtq_pkg::t_status'(i_m_tuser);
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with nothing pending",
                                              results));
                end else begin
                    want = pending_results.pop_front();
                    if (got.data !== want.data)
                        report_mismatch($sformatf("beat %0d out_data expected %h got %h",
                                                  results, want.data, got.data));
                    if (got.team !== want.team)
                        report_mismatch($sformatf("beat %0d out_team expected %h got %h",
                                                  results, want.team, got.team));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("beat %0d status expected %0d got %0d",
                                                  results, want.status, got.status));
                    if (got.occ !== want.occ)
                        report_mismatch($sformatf("beat %0d occupancy expected %0d got %0d",
                                                  results, want.occ, got.occ));
                end
                results++;
            end
        end
        o_fail_count   <= fails;
        o_pending      <= pending_results.size();
        o_result_count <= results;
        o_full_count   <= full_refusals;
        o_empty_count  <= empty_dequeues;
        o_insert_count <= mid_inserts;
        o_peak_occ     <= peak_occ;
    end

endmodule

### dv/grouped_team_queue_core_test.sv
`timescale 1ns / 100ps

module grouped_team_queue_core_test;

    localparam int RANDOM_BEATS   = 1600;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int LONG_STALL     = 400;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // in_data, in_team
    logic [0:0]  s_tuser  = '0;     // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // out_data, out_team, occupancy
    logic [1:0]  m_tuser;           // status

    int fail_count;
    int pending;
    int result_count;
    int full_count;
    int empty_count;
    int insert_count;
    int peak_occ;
    int beats_sent = 0;
    int idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grouped_team_queue_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    grouped_team_queue_core_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_full_count   (full_count),
        .o_empty_count  (empty_count),
        .o_insert_count (insert_count),
        .o_peak_occ     (peak_occ)
    );

    // hold the beat until the block takes it
    task automatic send_beat(input gtq_pkg::t_op op, input logic [15:0] data,
                             input logic [7:0] team, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {team, data};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        beats_sent++;
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 50);
    endfunction

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", idle_cycles);
            $display("grouped_team_queue_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        bit stalled;
        int r;
        int n;
        stalled = 1'b0;
        forever begin
            if (!stalled && result_count >= 500) begin
                // back up the output so the input side fills and stalls
                stalled = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(40, 150);
                end else if (r < 60) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(1, 8);
                end else if (r < 93) begin
                    m_tready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    n = $urandom_range(8, 50);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int       sent;
        int       phase_len;
        int       enq_pct;
        int       span;
        bit       quiet;
        bit       drained;
        bit       first;
        gtq_pkg::t_op op;
        logic [7:0]  team;
        logic [15:0] data;
        logic [7:0]  pool [6];
        sent    = 0;
        drained = 1'b0;
        first   = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty dequeue, field extremes, mid-queue inserts, tail append,
        // team entry cleared when its last member leaves
        send_beat(gtq_pkg::OP_DEQ, 16'hFFFF, 8'hFF, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'h0000, 8'h00, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'hFFFF, 8'hFF, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'h1234, 8'h00, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'hA5A5, 8'hFF, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'h5A5A, 8'h55, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'h00FF, 8'h00, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'hFF00, 8'hAA, 0);
        repeat (3) send_beat(gtq_pkg::OP_DEQ, 16'h0000, 8'h00, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'h8001, 8'h00, 0);
        send_beat(gtq_pkg::OP_ENQ, 16'h7FFE, 8'h55, 0);
        repeat (7) send_beat(gtq_pkg::OP_DEQ, 16'hFFFF, 8'hFF, 0);

        // random phases that swing the queue between empty and full
        while (sent < RANDOM_BEATS) begin
            if (first) begin
                phase_len = 80;
                enq_pct   = 100;
                first     = 1'b0;
            end else begin
                phase_len = $urandom_range(8, 120);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: enq_pct = 85;
                    4, 5, 6:    enq_pct = 55;
                    default:    enq_pct = 20;
                endcase
            end
            quiet = ($urandom_range(0, 3) == 0);
            span  = $urandom_range(1, 6);
            foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
            for (int k = 0; k < phase_len && sent < RANDOM_BEATS; k++) begin
                if (!drained && sent == RANDOM_BEATS / 2) begin
                    // stop offering until every pending result is back
                    drained = 1'b1;
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                op   = ($urandom_range(0, 99) < enq_pct) ? gtq_pkg::OP_ENQ : gtq_pkg::OP_DEQ;
                team = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, span - 1)]
                                                    : 8'($urandom_range(0, 255));
                data = 16'($urandom_range(0, 65535));
                send_beat(op, data, team, pick_gap(quiet));
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d beats, checked %0d results, peak occupancy %0d.",
                 beats_sent, result_count, peak_occ);
        $display("Seen: %0d refused when full, %0d dequeues on empty, %0d mid-queue inserts.",
                 full_count, empty_count, insert_count);
        if (fail_count == 0)
            $display("grouped_team_queue_core regression: pass");
        else
            $display("grouped_team_queue_core regression: fail");
        $finish;
    end

endmodule

### grouped_team_queue_core.f
hdl/gtq_pkg.sv
hdl/gtq_ram.sv
hdl/grouped_team_queue_core.sv
dv/grouped_team_queue_core_checker.sv
dv/grouped_team_queue_core_test.sv
